[src/rcpwm_pkg.sv]
// ----------------------------------------------------------------------------
// rcpwm_pkg
// Shared types and constants for the RC PWM pulse width meter.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

    localparam int CNT_W     = 18;
    localparam int TPM_W     = 10;
    localparam int OUT_W     = 15;
    localparam int PORTS     = 4;
    localparam int OPC_W     = 2;
    localparam int SHORT_MS  = 2;
    localparam int FRAME_MS  = 20;

    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(100);

    // stream packing
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = ((PORTS * OUT_W + 7) / 8) * 8;

    // command codes
    localparam logic [OPC_W-1:0] OPC_TICK  = 2'd0;
    localparam logic [OPC_W-1:0] OPC_SHORT = 2'd1;
    localparam logic [OPC_W-1:0] OPC_AVG   = 2'd2;

    // result kind
    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_AVG   = 1'b1;

    typedef logic [CNT_W-1:0] t_count;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SYNC = 3'b010,
        PH_READ = 3'b100
    } t_phase;

endpackage

[src/rcpwm_chan_finish.sv]
// ----------------------------------------------------------------------------
// rcpwm_chan_finish
// Turns one channel's raw high-tick count into its reported value: clamp to
// one..two milliseconds for a short read, per-frame average for a long read.
// ----------------------------------------------------------------------------
module rcpwm_chan_finish
    import rcpwm_pkg::*;
#(
    parameter int AVERAGE_FRAMES = 10
) (
    input  t_count             i_count,
    input  logic               i_kind,
    input  logic [TPM_W-1:0]   i_tpm_eff,
    output logic [OUT_W-1:0]   o_value
);

    // floor(c / AVERAGE_FRAMES) as (c * M) >> S, exact for every 18-bit c
    localparam int DIV_SHIFT = CNT_W + $clog2(AVERAGE_FRAMES);
    localparam int MUL_W     = DIV_SHIFT + 1;
    localparam longint DIV_MUL_L =
        ((64'd1 << DIV_SHIFT) + AVERAGE_FRAMES - 1) / AVERAGE_FRAMES;
    localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(DIV_MUL_L);
    localparam int PROD_W    = CNT_W + MUL_W;

    logic [PROD_W-1:0] prod;
    t_count            quot;
    logic [TPM_W:0]    lim_hi;
    t_count            clamped;

    assign prod   = PROD_W'(i_count) * PROD_W'(DIV_MUL);
    assign quot   = prod[DIV_SHIFT +: CNT_W];
    assign lim_hi = {i_tpm_eff, 1'b0};

    always_comb begin
        if (i_count > CNT_W'(lim_hi)) begin
            clamped = CNT_W'(lim_hi);
        end else if (i_count < CNT_W'(i_tpm_eff)) begin
            clamped = CNT_W'(i_tpm_eff);
        end else begin
            clamped = i_count;
        end
    end

    assign o_value = (i_kind == KIND_AVG) ? quot[OUT_W-1:0] : clamped[OUT_W-1:0];

endmodule

[src/rc_pwm_pulse_width_meter_unit.sv]
// ----------------------------------------------------------------------------
// rc_pwm_pulse_width_meter_unit
// Four-channel RC PWM high-time meter with short clamped and long average reads.
// ----------------------------------------------------------------------------
// Takes one request per clock while input ready is high: sample ticks,
// start-short-read and start-average-read commands (tuser selects which).
// Every tick taken while a read counts updates the per-channel high counters
// and the window counter in the cycle it is taken. The tick that closes a
// window is copied to a result stage, and the clamp or divide-by-AVERAGE_FRAMES
// (reciprocal multiply, one per channel) fills the output register as soon as
// it is free; the result shows on m_axis from there. Input ready only drops
// while both the result stage and the output register hold results that
// m_axis has not taken. A start command aborts any read in progress without a
// result. ticks_per_ms is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_width_meter_unit
    import rcpwm_pkg::*;
#(
    parameter int CHANNELS       = 4,
    parameter int AVERAGE_FRAMES = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config: ticks_per_ms
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [TPM_W-1:0]      i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [0] wait_sync, [4:1] pin_levels
    input  logic [OPC_W-1:0]      s_axis_tuser,  // [1:0] opcode
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [14:0] ch0, [29:15] ch1,
                                                 // [44:30] ch2, [59:45] ch3
    output logic                  m_axis_tuser   // [0] result_kind
);

    localparam int FRAME_MUL = FRAME_MS * AVERAGE_FRAMES;
    localparam int FMUL_W    = $clog2(FRAME_MUL + 1);
    localparam int AP_W      = (TPM_W + FMUL_W > CNT_W) ? TPM_W + FMUL_W : CNT_W + 1;

    // config
    logic [TPM_W-1:0] r_tpm;
    logic [TPM_W-1:0] tpm_eff;

    // read state
    t_phase r_phase, n_phase;
    logic   r_mode, n_mode;
    logic   r_prev, n_prev;
    t_count r_win, n_win;
    t_count r_cnt [PORTS];
    t_count n_cnt [PORTS];

    // result stage and output register
    logic   r_raw_valid;
    t_count r_raw_cnt [PORTS];
    logic   r_raw_kind;
    logic [TPM_W-1:0] r_raw_tpm;
    logic   r_out_valid;
    logic [OUT_W-1:0] r_out_val [PORTS];
    logic   r_out_kind;
    logic [OUT_W-1:0] fin_val [PORTS];

    logic   accept;
    logic   out_ready;
    logic   raw_adv;
    logic   raw_load;
    logic   wait_sync;
    logic [PORTS-1:0] pins;

    logic [TPM_W:0] short_tgt;
    logic [AP_W-1:0] avg_prod;
    t_count avg_tgt;
    t_count target;
    t_count base_win;
    t_count base_cnt [PORTS];
    logic   sync_edge;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpm <= TPM_RESET;
        end else if (i_cfg_valid) begin
            r_tpm <= i_cfg_data;
        end
    end

    assign tpm_eff = (r_tpm == '0) ? TPM_W'(1) : r_tpm;

    // window target, saturated to the counter range
    assign short_tgt = (TPM_W + 1)'(tpm_eff) * (TPM_W + 1)'(SHORT_MS);
    assign avg_prod  = AP_W'(tpm_eff) * AP_W'(FRAME_MUL);
    assign avg_tgt   = (avg_prod > AP_W'(CNT_MAX)) ? CNT_MAX : avg_prod[CNT_W-1:0];
    assign target    = r_mode ? avg_tgt : CNT_W'(short_tgt);

    // handshake
    assign out_ready     = !r_out_valid || m_axis_tready;
    assign raw_adv       = r_raw_valid && out_ready;
    assign s_axis_tready = !r_raw_valid || out_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign wait_sync = s_axis_tdata[0];
    assign pins      = s_axis_tdata[PORTS:1];
    assign sync_edge = (r_phase == PH_SYNC) && pins[0] && !r_prev;

    // counters restart from zero on the sync edge
    always_comb begin
        for (int i = 0; i < PORTS; i++) begin
            base_cnt[i] = (r_phase == PH_SYNC) ? '0 : r_cnt[i];
        end
        base_win = (r_phase == PH_SYNC) ? '0 : r_win;
    end

    always_comb begin
        n_phase  = r_phase;
        n_mode   = r_mode;
        n_prev   = r_prev;
        n_win    = r_win;
        raw_load = 1'b0;
        for (int i = 0; i < PORTS; i++) begin
            n_cnt[i] = r_cnt[i];
        end
        if (accept) begin
            case (s_axis_tuser)
                OPC_SHORT, OPC_AVG: begin
                    n_mode = (s_axis_tuser == OPC_AVG);
                    n_prev = 1'b1;
                    n_win  = '0;
                    for (int i = 0; i < PORTS; i++) begin
                        n_cnt[i] = '0;
                    end
                    n_phase = (s_axis_tuser == OPC_SHORT && wait_sync) ? PH_SYNC : PH_READ;
                end
                OPC_TICK: begin
                    if (r_phase == PH_SYNC) begin
                        n_prev = pins[0];
                    end
                    if (r_phase == PH_READ || sync_edge) begin
                        for (int i = 0; i < PORTS; i++) begin
                            n_cnt[i] = base_cnt[i]
                                + CNT_W'(pins[i] && (i < CHANNELS) && base_cnt[i] != CNT_MAX);
                        end
                        n_win   = base_win + CNT_W'(base_win != CNT_MAX);
                        n_phase = PH_READ;
                        if (n_win >= target) begin
                            raw_load = 1'b1;
                            n_phase  = PH_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_mode  <= 1'b0;
            r_prev  <= 1'b1;
            r_win   <= '0;
            for (int i = 0; i < PORTS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_prev  <= n_prev;
            r_win   <= n_win;
            for (int i = 0; i < PORTS; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_valid <= 1'b0;
        end else if (raw_load) begin
            r_raw_valid <= 1'b1;
        end else if (raw_adv) begin
            r_raw_valid <= 1'b0;
        end
    end

    // clamp limits follow the register value seen by the closing tick
    always_ff @(posedge i_clk) begin
        if (raw_load) begin
            r_raw_kind <= r_mode ? KIND_AVG : KIND_SHORT;
            r_raw_tpm  <= tpm_eff;
            for (int i = 0; i < PORTS; i++) begin
                r_raw_cnt[i] <= n_cnt[i];
            end
        end
    end

    for (genvar g = 0; g < PORTS; g++) begin : g_fin
        rcpwm_chan_finish #(
            .AVERAGE_FRAMES(AVERAGE_FRAMES)
        ) u_fin (
            .i_count   (r_raw_cnt[g]),
            .i_kind    (r_raw_kind),
            .i_tpm_eff (r_raw_tpm),
            .o_value   (fin_val[g])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (raw_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (raw_adv) begin
            r_out_kind <= r_raw_kind;
            for (int i = 0; i < PORTS; i++) begin
                r_out_val[i] <= fin_val[i];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;

    always_comb begin
        m_axis_tdata = '0;
        for (int i = 0; i < PORTS; i++) begin
            m_axis_tdata[i*OUT_W +: OUT_W] = r_out_val[i];
        end
    end

endmodule

[src/rcpwm_checker.sv]
// ----------------------------------------------------------------------------
// rcpwm_checker
// Port-level checks for the RC PWM pulse width meter, bound to the top level.
// ----------------------------------------------------------------------------
module rcpwm_checker
    import rcpwm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [OPC_W-1:0]      s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a new result must trace back to an accepted tick request
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == OPC_TICK, 2))
        else $error("result without a closing tick");

    // input only stalls behind a waiting result
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind rc_pwm_pulse_width_meter_unit rcpwm_checker u_rcpwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/rc_pwm_pulse_width_meter_unit_tb.sv]
// ----------------------------------------------------------------------------
// rc_pwm_pulse_width_meter_unit_tb
// Self-checking bench for the four-channel RC PWM pulse width meter.
// Streams tick and start requests under random backpressure on both sides.
// A cycle-free model of the meter predicts every short and average read, and
// each result on m_axis is checked against it field by field. ticks_per_ms is
// swept over small values, zero and the top of its range between drained
// phases.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_width_meter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcpwm_pkg::*;

    localparam int CHANNELS       = 4;
    localparam int AVERAGE_FRAMES = 10;
    localparam int ITEMS_GOAL     = 1150;
    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTS     = 100;
    localparam int PARTIAL_MAX    = 40;

    localparam logic [OPC_W-1:0] OPC_RESERVED = 2'd3;

    typedef struct packed {
        logic [OPC_W-1:0] opc;
        logic             ws;
        logic [PORTS-1:0] pins;
    } t_pwm_request;

    typedef struct packed {
        logic [PORTS-1:0][OUT_W-1:0] count;
        logic                        kind;
    } t_pwm_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [TPM_W-1:0]      i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [0] wait_sync, [4:1] pin_levels
    logic [OPC_W-1:0]      s_axis_tuser  = '0;  // [1:0] opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [14:0] ch0, [29:15] ch1,
                                                // [44:30] ch2, [59:45] ch3
    logic                  m_axis_tuser;        // [0] result_kind

    rc_pwm_pulse_width_meter_unit #(
        .CHANNELS       (CHANNELS),
        .AVERAGE_FRAMES (AVERAGE_FRAMES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_pwm_request request_q[$];
    t_pwm_result  pulse_width_q[$];

    int unsigned pushed_cnt   = 0;
    int unsigned taken_cnt    = 0;
    int unsigned result_cnt   = 0;
    int unsigned cfg_writes   = 0;
    int unsigned stall_cycles = 0;
    int unsigned err_cnt      = 0;
    int unsigned work_items   = 0;
    int unsigned hold_left    = 0;
    int unsigned src_gap      = 0;
    int unsigned snk_gap      = 0;
    bit          in_taken     = 1'b0;
    bit          idle_on      = 1'b1;
    bit          hold_req     = 1'b0;

    logic [TPM_W-1:0] plan_tpm = TPM_RESET;

    // meter model state
    t_phase           mdl_phase     = PH_IDLE;
    logic             mdl_avg       = 1'b0;
    logic             mdl_prev_sync = 1'b1;
    int unsigned      mdl_window    = 0;
    int unsigned      mdl_high[PORTS] = '{default: 0};
    logic [TPM_W-1:0] mdl_tpm       = TPM_RESET;

    function automatic int unsigned eff_tpm(input logic [TPM_W-1:0] v);
        return (v == '0) ? 1 : v;
    endfunction

    function automatic int unsigned read_length(input logic avg, input logic [TPM_W-1:0] v);
        int unsigned n;
        n = avg ? FRAME_MS * AVERAGE_FRAMES * eff_tpm(v) : SHORT_MS * eff_tpm(v);
        return (n > CNT_MAX) ? CNT_MAX : n;
    endfunction

    task automatic clear_window();
        for (int ch = 0; ch < PORTS; ch++) mdl_high[ch] = 0;
        mdl_window = 0;
    endtask

    task automatic predict_pulse_widths(input t_pwm_request rq);
        t_pwm_result r;
        bit          counting;
        int unsigned lo, hi, v;
        if (rq.opc == OPC_SHORT || rq.opc == OPC_AVG) begin
            mdl_avg       = (rq.opc == OPC_AVG);
            clear_window();
            mdl_prev_sync = 1'b1;
            mdl_phase     = (rq.opc == OPC_SHORT && rq.ws) ? PH_SYNC : PH_READ;
        end else if (rq.opc == OPC_TICK && mdl_phase != PH_IDLE) begin
            counting = 1'b1;
            if (mdl_phase == PH_SYNC) begin
                counting      = rq.pins[0] && !mdl_prev_sync;
                mdl_prev_sync = rq.pins[0];
                if (counting) begin
                    // counters restart on the edge; the edge tick is the first one
                    clear_window();
                    mdl_phase = PH_READ;
                end
            end
            if (counting) begin
                for (int ch = 0; ch < PORTS; ch++) begin
                    if (ch < CHANNELS && rq.pins[ch] && mdl_high[ch] < CNT_MAX)
                        mdl_high[ch]++;
                end
                if (mdl_window < CNT_MAX) mdl_window++;
                // target follows the live register, so a lowered value ends early
                if (mdl_window >= read_length(mdl_avg, mdl_tpm)) begin
                    lo = eff_tpm(mdl_tpm);
                    hi = SHORT_MS * lo;
                    for (int ch = 0; ch < PORTS; ch++) begin
                        if (mdl_avg)
                            v = mdl_high[ch] / AVERAGE_FRAMES;
                        else
                            v = (mdl_high[ch] > hi) ? hi : ((mdl_high[ch] < lo) ? lo : mdl_high[ch]);
                        r.count[ch] = OUT_W'(v);
                    end
                    r.kind = mdl_avg ? KIND_AVG : KIND_SHORT;
                    pulse_width_q.push_back(r);
                    mdl_phase = PH_IDLE;
                end
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        if (err_cnt < MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    // sample both handshakes, run the model and check results
    always @(posedge i_clk) begin : monitor
        t_pwm_result got, want;
        bit          active;
        active   = 1'b0;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                active     = 1'b1;
                result_cnt++;
                got.count  = m_axis_tdata[PORTS*OUT_W-1:0];
                got.kind   = m_axis_tuser;
                if (pulse_width_q.size() == 0) begin
                    note_mismatch($sformatf("result %h kind %0d with none pending",
                                            got.count, got.kind));
                end else begin
                    want = pulse_width_q.pop_front();
                    for (int ch = 0; ch < PORTS; ch++) begin
                        if (got.count[ch] !== want.count[ch])
                            note_mismatch($sformatf("result %0d ch%0d count %0d, want %0d",
                                                    result_cnt, ch, got.count[ch],
                                                    want.count[ch]));
                    end
                    if (got.kind !== want.kind)
                        note_mismatch($sformatf("result %0d kind %0d, want %0d",
                                                result_cnt, got.kind, want.kind));
                end
            end
            // a request taken on the same edge as a write still sees the old value
            if (s_axis_tvalid && s_axis_tready) begin
                active   = 1'b1;
                in_taken = 1'b1;
                taken_cnt++;
                predict_pulse_widths('{opc: s_axis_tuser, ws: s_axis_tdata[0],
                                       pins: s_axis_tdata[PORTS:1]});
            end
            if (i_cfg_valid && o_cfg_ready) begin
                active  = 1'b1;
                mdl_tpm = i_cfg_data;
                cfg_writes++;
            end
        end
        stall_cycles = active ? 0 : stall_cycles + 1;
    end

    always @(negedge i_clk) begin : driver
        t_pwm_request rq;
        if (i_rst_n && (in_taken || !s_axis_tvalid)) begin
            if (src_gap != 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (request_q.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
                src_gap = $urandom_range(0, 11);
                s_axis_tvalid <= 1'b0;
            end else if (request_q.size() != 0) begin
                rq = request_q.pop_front();
                s_axis_tuser  <= rq.opc;
                s_axis_tdata  <= IN_DATA_W'({rq.pins, rq.ws});
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : sink
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req) begin
            // long hold-off: lets results back up into the input
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (snk_gap != 0) begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic push_request(input logic [OPC_W-1:0] opc, input logic ws,
                                input logic [PORTS-1:0] pins, input bit counted);
        request_q.push_back('{opc: opc, ws: ws, pins: pins});
        pushed_cnt++;
        if (counted) work_items++;
    endtask

    // duty[ch] of 0..4 sets the chance of a high line in quarters
    function automatic logic [PORTS-1:0] duty_pins(input logic [PORTS-1:0][2:0] duty);
        logic [PORTS-1:0] p;
        for (int ch = 0; ch < PORTS; ch++) p[ch] = ($urandom_range(0, 3) < duty[ch]);
        return p;
    endfunction

    // start request then ticks; a partial read is cut short by the next start
    task automatic gen_read(input bit avg, input bit ws, input bit full);
        logic [PORTS-1:0][2:0] duty;
        int unsigned           len;
        for (int ch = 0; ch < PORTS; ch++) duty[ch] = 3'($urandom_range(0, 4));
        len = read_length(avg, plan_tpm);
        if (!full) len = $urandom_range(0, ((len > PARTIAL_MAX) ? PARTIAL_MAX : len) - 1);
        push_request(avg ? OPC_AVG : OPC_SHORT, ws, PORTS'($urandom), 1'b1);
        if (ws && !avg) begin
            repeat ($urandom_range(0, 3))
                push_request(OPC_TICK, 1'($urandom), duty_pins(duty), 1'b1);
            push_request(OPC_TICK, 1'($urandom), duty_pins(duty) & ~PORTS'(1), 1'b1);
            if (len != 0) begin
                push_request(OPC_TICK, 1'($urandom), duty_pins(duty) | PORTS'(1), 1'b1);
                len--;
            end
        end
        repeat (len) begin
            if ($urandom_range(0, 19) == 0)
                push_request(OPC_RESERVED, 1'($urandom), PORTS'($urandom), 1'b0);
            push_request(OPC_TICK, 1'($urandom), duty_pins(duty), 1'b1);
        end
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 4))
            push_request($urandom_range(0, 1) ? OPC_RESERVED : OPC_TICK,
                         1'($urandom), PORTS'($urandom), 1'b0);
    endtask

    // sender pause: wait until all requests are taken and all results are back, then idle
    task automatic settle();
        while (taken_cnt != pushed_cnt || pulse_width_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tpm(input logic [TPM_W-1:0] v);
        int unsigned seen;
        seen     = cfg_writes;
        plan_tpm = v;
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        while (cfg_writes == seen) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("rc_pwm_pulse_width_meter_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned sel;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        write_tpm(TPM_W'(2));
        // idle tick and reserved opcode do nothing
        push_request(OPC_TICK, 1'b1, 4'hF, 1'b0);
        push_request(OPC_RESERVED, 1'b1, 4'hF, 1'b0);
        // short read, start pins ignored, reserved opcode mid-window
        push_request(OPC_SHORT, 1'b0, 4'hF, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'hF, 1'b1);
        push_request(OPC_TICK, 1'b1, 4'h5, 1'b1);
        push_request(OPC_RESERVED, 1'b0, 4'hF, 1'b0);
        push_request(OPC_TICK, 1'b0, 4'h3, 1'b1);
        push_request(OPC_TICK, 1'b1, 4'h1, 1'b1);
        // synced read: a line already high is no edge
        push_request(OPC_SHORT, 1'b1, 4'h0, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'h1, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'h0, 1'b1);
        push_request(OPC_TICK, 1'b1, 4'hF, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'hE, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'hF, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'h0, 1'b1);
        // average read aborted by a short read
        push_request(OPC_AVG, 1'b1, 4'hF, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'hF, 1'b1);
        push_request(OPC_SHORT, 1'b0, 4'h0, 1'b1);
        repeat (4) push_request(OPC_TICK, 1'b0, 4'hF, 1'b1);
        settle();
        // zero register acts as one; all-low lines clamp up
        write_tpm('0);
        push_request(OPC_SHORT, 1'b0, 4'hF, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'h0, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'h0, 1'b1);
        settle();
        // lowering the register mid-read ends it on the next tick
        write_tpm(TPM_W'(5));
        push_request(OPC_SHORT, 1'b0, 4'h0, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'hA, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'h5, 1'b1);
        push_request(OPC_TICK, 1'b0, 4'hF, 1'b1);
        settle();
        write_tpm(TPM_W'(1));
        push_request(OPC_TICK, 1'b0, 4'hF, 1'b1);
        settle();

        // back-to-back quick reads while the result side is held off
        write_tpm(TPM_W'(1));
        hold_req = 1'b1;
        repeat (24) gen_read(1'b0, 1'b0, 1'b1);
        settle();

        while (work_items < ITEMS_GOAL) begin
            sel = $urandom_range(0, 9);
            write_tpm((sel == 0) ? TPM_W'(0) : TPM_W'($urandom_range(1, 6)));
            repeat ($urandom_range(3, 8)) begin
                sel = $urandom_range(0, 9);
                if (sel == 0 && eff_tpm(plan_tpm) <= 2)
                    gen_read(1'b1, 1'($urandom), 1'b1);
                else if (sel <= 6)
                    gen_read(1'b0, 1'($urandom), 1'b1);
                else if (sel <= 8)
                    gen_read($urandom_range(0, 3) == 0, 1'($urandom), 1'b0);
                else
                    gen_noise();
            end
            settle();
        end

        idle_on = 1'b0;
        // top of the register range keeps a read open, then a lower value closes it
        write_tpm(TPM_W'(1023));
        push_request(OPC_SHORT, 1'b0, 4'h0, 1'b1);
        repeat (40) push_request(OPC_TICK, 1'($urandom), PORTS'($urandom), 1'b1);
        settle();
        write_tpm(TPM_W'(1000));
        push_request(OPC_TICK, 1'($urandom), PORTS'($urandom), 1'b1);
        settle();
        write_tpm(TPM_W'(12));
        push_request(OPC_TICK, 1'($urandom), PORTS'($urandom), 1'b1);
        settle();
        write_tpm(TPM_W'(2));
        repeat (16) gen_read(1'b0, 1'($urandom), 1'b1);
        settle();

        $display("covered %0d requests, %0d results, %0d ticks_per_ms writes (0 to 1023)",
                 taken_cnt, result_cnt, cfg_writes);
        $display("short reads with and without sync, average reads, aborts, long output stall");
        if (err_cnt == 0) begin
            $display("rc_pwm_pulse_width_meter_unit regression: pass");
        end else begin
            $display("rc_pwm_pulse_width_meter_unit regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
src/rcpwm_pkg.sv
src/rcpwm_chan_finish.sv
src/rc_pwm_pulse_width_meter_unit.sv
src/rcpwm_checker.sv
tb/rc_pwm_pulse_width_meter_unit_tb.sv
